// ----- hw/rtl/lds_pkg.sv -----
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants of the LOOK disk request scheduler.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int TRACK_W   = 13;
  localparam int IN_TAG_W  = 8;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic add;         // append request, or report full
    logic pick_empty;  // pick on an empty queue
    logic scan_start;  // latch head and direction, clear the best candidates
    logic scan_run;    // stream entries through the distance compare
    logic select;      // choose the winner, set up the removal
    logic shift_run;   // move the later entries down one place
    logic finish;      // drop the count, post the dispatch beat
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic empty;       // no pending request
    logic sweep_done;  // every entry read and the last read consumed
  } stat_t;

endpackage

// ----- hw/rtl/lds_ram.sv -----
// ----------------------------------------------------------------------------
// lds_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lds_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/lds_ctrl.sv -----
// ----------------------------------------------------------------------------
// lds_ctrl
// Sequencer of the scheduler: add, empty pick, scan, select, shift, finish.
// ----------------------------------------------------------------------------
module lds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          kind_i,
  input  lds_pkg::stat_t stat_i,
  output lds_pkg::cmd_t  cmd_o,
  output logic          busy_o
);
  import lds_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && kind_i && !stat_i.empty) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.sweep_done) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat_i.sweep_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.add        = accept && !kind_i;
        cmd_o.pick_empty = accept && kind_i && stat_i.empty;
        cmd_o.scan_start = accept && kind_i && !stat_i.empty;
      end
      S_SCAN: begin
        cmd_o.scan_run = !stat_i.sweep_done;
        cmd_o.select   = stat_i.sweep_done;
      end
      S_SHIFT: begin
        cmd_o.shift_run = !stat_i.sweep_done;
        cmd_o.finish    = stat_i.sweep_done;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/lds_datapath.sv -----
// ----------------------------------------------------------------------------
// lds_datapath
// Request store, distance compare, candidate registers and result registers.
// ----------------------------------------------------------------------------
module lds_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lds_pkg::cmd_t                    cmd_i,
  output lds_pkg::stat_t                   stat_o,
  input  logic [lds_pkg::TRACK_W-1:0]      track_i,
  input  logic [lds_pkg::IN_TAG_W-1:0]     request_tag_i,
  input  logic [lds_pkg::TRACK_W-1:0]      head_position_i,
  input  logic                             direction_up_i,
  output logic [lds_pkg::STATUS_W-1:0]     status_o,
  output logic [lds_pkg::TRACK_W-1:0]      picked_track_o,
  output logic [lds_pkg::IN_TAG_W-1:0]     picked_tag_o,
  output logic [lds_pkg::COUNT_W-1:0]      pending_count_o,
  output logic                             done_o
);
  import lds_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = TRACK_W + TAG_BITS;

  // queue control
  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic          full;

  // pick context and best candidates on each side of the head
  logic [TRACK_W-1:0] head_q, head_d;
  logic               up_q, up_d;
  logic               fwd_found_q, fwd_found_d, bwd_found_q, bwd_found_d;
  logic [TRACK_W-1:0] fwd_dist_q, fwd_dist_d, bwd_dist_q, bwd_dist_d;
  logic [AW-1:0]      fwd_idx_q, fwd_idx_d, bwd_idx_q, bwd_idx_d;
  logic [WW-1:0]      fwd_word_q, fwd_word_d, bwd_word_q, bwd_word_d;
  logic [WW-1:0]      pick_word_q, pick_word_d;

  // result registers
  logic                done_q, done_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [TRACK_W-1:0]  res_track_q, res_track_d;
  logic [IN_TAG_W-1:0] res_tag_q, res_tag_d;
  logic [COUNT_W-1:0]  res_count_q, res_count_d;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] rd_word;

  // compare
  logic [TRACK_W-1:0] rd_track;
  logic               ge, eq, fwd_ok, bwd_ok;
  logic [TRACK_W-1:0] span;

  logic [31:0]         tag_in32;
  logic [TAG_BITS-1:0] tag_in;
  logic [31:0]         pick_tag32;
  logic [31:0]         count32;

  assign tag_in32   = 32'(request_tag_i);
  assign tag_in     = tag_in32[TAG_BITS-1:0];
  assign pick_tag32 = 32'(pick_word_q[TAG_BITS-1:0]);
  assign count32    = 32'(occ_d);

  assign full              = (occ_q == CW'(QUEUE_DEPTH));
  assign stat_o.empty      = (occ_q == '0);
  assign stat_o.sweep_done = (rd_ptr_q == occ_q) && !rd_vld_q;

  assign rd_track = rd_word[WW-1:TAG_BITS];
  assign ge       = (rd_track >= head_q);
  assign eq       = (rd_track == head_q);
  assign span     = ge ? (rd_track - head_q) : (head_q - rd_track);
  // the head's own track counts for the sweep side only
  assign fwd_ok   = up_q ? ge : (!ge || eq);
  assign bwd_ok   = up_q ? !ge : (ge && !eq);

  assign ram_we    = (cmd_i.add && !full) || (cmd_i.shift_run && rd_vld_q);
  assign ram_waddr = cmd_i.add ? occ_q[AW-1:0] : wr_ptr_q;
  assign ram_wdata = cmd_i.add ? {track_i, tag_in} : rd_word;

  lds_ram #(
    .WIDTH(WW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_ptr_q[AW-1:0]),
    .rdata_o(rd_word)
  );

  always_comb begin
    occ_d        = occ_q;
    rd_ptr_d     = rd_ptr_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    wr_ptr_d     = wr_ptr_q;
    head_d       = head_q;
    up_d         = up_q;
    fwd_found_d  = fwd_found_q;
    fwd_dist_d   = fwd_dist_q;
    fwd_idx_d    = fwd_idx_q;
    fwd_word_d   = fwd_word_q;
    bwd_found_d  = bwd_found_q;
    bwd_dist_d   = bwd_dist_q;
    bwd_idx_d    = bwd_idx_q;
    bwd_word_d   = bwd_word_q;
    pick_word_d  = pick_word_q;
    done_d       = 1'b0;
    res_status_d = res_status_q;
    res_track_d  = res_track_q;
    res_tag_d    = res_tag_q;

    // stream one read per cycle while entries remain
    if ((cmd_i.scan_run || cmd_i.shift_run) && (rd_ptr_q != occ_q)) begin
      rd_vld_d = 1'b1;
      rd_idx_d = rd_ptr_q[AW-1:0];
      rd_ptr_d = rd_ptr_q + CW'(1);
    end

    if (cmd_i.add) begin
      done_d       = 1'b1;
      res_track_d  = '0;
      res_tag_d    = '0;
      if (full) begin
        res_status_d = ST_FULL;
      end else begin
        res_status_d = ST_ADDED;
        occ_d        = occ_q + CW'(1);
      end
    end

    if (cmd_i.pick_empty) begin
      done_d       = 1'b1;
      res_status_d = ST_EMPTY;
      res_track_d  = '0;
      res_tag_d    = '0;
    end

    if (cmd_i.scan_start) begin
      head_d      = head_position_i;
      up_d        = direction_up_i;
      rd_ptr_d    = '0;
      fwd_found_d = 1'b0;
      bwd_found_d = 1'b0;
    end

    // strict less-than keeps the earliest arrival on equal distance
    if (cmd_i.scan_run && rd_vld_q) begin
      if (fwd_ok && (!fwd_found_q || (span < fwd_dist_q))) begin
        fwd_found_d = 1'b1;
        fwd_dist_d  = span;
        fwd_idx_d   = rd_idx_q;
        fwd_word_d  = rd_word;
      end
      if (bwd_ok && (!bwd_found_q || (span < bwd_dist_q))) begin
        bwd_found_d = 1'b1;
        bwd_dist_d  = span;
        bwd_idx_d   = rd_idx_q;
        bwd_word_d  = rd_word;
      end
    end

    if (cmd_i.select) begin
      if (fwd_found_q) begin
        pick_word_d = fwd_word_q;
        wr_ptr_d    = fwd_idx_q;
        rd_ptr_d    = CW'(fwd_idx_q) + CW'(1);
      end else begin
        pick_word_d = bwd_word_q;
        wr_ptr_d    = bwd_idx_q;
        rd_ptr_d    = CW'(bwd_idx_q) + CW'(1);
      end
    end

    if (cmd_i.shift_run && rd_vld_q) begin
      wr_ptr_d = wr_ptr_q + AW'(1);
    end

    if (cmd_i.finish) begin
      done_d       = 1'b1;
      occ_d        = occ_q - CW'(1);
      res_status_d = ST_DISPATCHED;
      res_track_d  = pick_word_q[WW-1:TAG_BITS];
      res_tag_d    = pick_tag32[IN_TAG_W-1:0];
    end

    res_count_d = count32[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      fwd_found_q <= 1'b0;
      bwd_found_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_vld_q    <= rd_vld_d;
      fwd_found_q <= fwd_found_d;
      bwd_found_q <= bwd_found_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    wr_ptr_q     <= wr_ptr_d;
    head_q       <= head_d;
    up_q         <= up_d;
    fwd_dist_q   <= fwd_dist_d;
    fwd_idx_q    <= fwd_idx_d;
    fwd_word_q   <= fwd_word_d;
    bwd_dist_q   <= bwd_dist_d;
    bwd_idx_q    <= bwd_idx_d;
    bwd_word_q   <= bwd_word_d;
    pick_word_q  <= pick_word_d;
    res_status_q <= res_status_d;
    res_track_q  <= res_track_d;
    res_tag_q    <= res_tag_d;
    res_count_q  <= res_count_d;
  end

  assign done_o          = done_q;
  assign status_o        = res_status_q;
  assign picked_track_o  = res_track_q;
  assign picked_tag_o    = res_tag_q;
  assign pending_count_o = res_count_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.add && full) |=> $stable(occ_q))
    else $error("dropped request changed occupancy");

  a_finish_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (occ_q == $past(occ_q) - CW'(1)))
    else $error("dispatch did not remove exactly one request");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift_run && rd_vld_q) |-> (rd_idx_q == wr_ptr_q + AW'(1)))
    else $error("shift write does not trail its read by one place");

  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.select |-> (fwd_found_q || bwd_found_q))
    else $error("scan of a non-empty queue found no candidate");

endmodule

// ----- hw/rtl/look_disk_scheduler.sv -----
// ----------------------------------------------------------------------------
// look_disk_scheduler
// LOOK disk request scheduler: queue of pending requests with pick by sweep.
// ----------------------------------------------------------------------------
// A beat is accepted at a rising edge with start_i high and busy_o low. Every
// beat produces exactly one result beat, shown for one cycle with done_o high;
// the receiver cannot stall, so capture it on that cycle. An add beat
// (kind_i = 0) or a pick on an empty queue finishes at once: its result comes
// on the next cycle and busy_o stays low, so these beats may follow every
// cycle. A pick on a non-empty queue holds busy_o high through its scan and
// shift states and posts its result in the cycle in which busy_o falls. The
// request RAM serves one read per cycle: one pass reads every entry through
// the distance compare, a second pass moves the later entries down one
// place to keep arrival order. Direction and head updates stay with the
// caller. Request tags are kept to TAG_BITS bits.
// ----------------------------------------------------------------------------
module look_disk_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         kind_i,
  input  logic [lds_pkg::TRACK_W-1:0]  track_i,
  input  logic [lds_pkg::IN_TAG_W-1:0] request_tag_i,
  input  logic [lds_pkg::TRACK_W-1:0]  head_position_i,
  input  logic                         direction_up_i,
  output logic                         done_o,
  output logic [lds_pkg::STATUS_W-1:0] status_o,
  output logic [lds_pkg::TRACK_W-1:0]  picked_track_o,
  output logic [lds_pkg::IN_TAG_W-1:0] picked_tag_o,
  output logic [lds_pkg::COUNT_W-1:0]  pending_count_o
);
  import lds_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decides the step, never touches the data
  lds_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .kind_i(kind_i),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy_o(busy_o)
  );

  // store, compare and result registers
  lds_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .track_i        (track_i),
    .request_tag_i  (request_tag_i),
    .head_position_i(head_position_i),
    .direction_up_i (direction_up_i),
    .status_o       (status_o),
    .picked_track_o (picked_track_o),
    .picked_tag_o   (picked_tag_o),
    .pending_count_o(pending_count_o),
    .done_o         (done_o)
  );

endmodule
